// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, quiet while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== sv/crc8fr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fr_pkg
// types, codes and the crc-8 byte update for the framed time receiver
// ----------------------------------------------------------------------------
package crc8fr_pkg;

	localparam int unsigned FRAME_LEN   = 10;
	localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
	localparam int unsigned IDX_W       = 4;
	localparam int unsigned TICK_W      = 20;
	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W  = 104;

	localparam logic [7:0]        CRC_POLY        = 8'h31;
	localparam logic [7:0]        START_RST       = 8'hfe;
	localparam logic [TICK_W-1:0] TIMEOUT_RST     = TICK_W'(100000);
	localparam logic [7:0]        FRAME_LEN_BYTE  = 8'(FRAME_LEN);
	localparam logic [IDX_W-1:0]  LAST_IDX        = IDX_W'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0]  STORE_DEPTH_IDX = IDX_W'(STORE_DEPTH);

	// input kind carried on tuser
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_START   = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEN,
		PH_CRC,
		PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		ST_ECHO      = 3'd0,
		ST_GOOD      = 3'd1,
		ST_BAD_START = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_TIMEOUT   = 3'd4,
		ST_CRC_ERR   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]        start_byte;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [7:0]  tx_byte;
		logic [7:0]  received_crc;
		logic [7:0]  computed_crc;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  weekday;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [15:0] millis;
	} res_t;

	// msb-first crc-8, one byte per call
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/crc8fr_regs.sv =====
// ----------------------------------------------------------------------------
// crc8fr_regs
// apb register file: start byte and inter-byte timeout
// ----------------------------------------------------------------------------
module crc8fr_regs
	import crc8fr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [7:0]        start_byte_q;
	logic [TICK_W-1:0] timeout_ticks_q;
	logic              wr_en;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q    <= START_RST;
			timeout_ticks_q <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_START:   start_byte_q    <= pwdata[7:0];
				REG_TIMEOUT: timeout_ticks_q <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_START:   prdata = CFG_DATA_W'(start_byte_q);
			REG_TIMEOUT: prdata = CFG_DATA_W'(timeout_ticks_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.start_byte    = start_byte_q;
	assign cfg.timeout_ticks = timeout_ticks_q;

endmodule

// ===== sv/crc8fr_core.sv =====
// ----------------------------------------------------------------------------
// crc8fr_core
// frame state machine, running crc, payload store and result decode
// ----------------------------------------------------------------------------
module crc8fr_core
	import crc8fr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output res_t       res
);

	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] idle_ticks_q, idle_ticks_d;
	logic [7:0]        expected_crc_q, expected_crc_d;
	logic [7:0]        running_crc_q, running_crc_d;
	logic [IDX_W-1:0]  byte_index_q, byte_index_d;
	logic [7:0]        payload_q [STORE_DEPTH];
	logic              store_we;
	logic [7:0]        crc_nxt;

	assign crc_nxt = crc8_update(running_crc_q, rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			idle_ticks_q   <= '0;
			expected_crc_q <= '0;
			running_crc_q  <= '0;
			byte_index_q   <= '0;
		end else begin
			phase_q        <= phase_d;
			idle_ticks_q   <= idle_ticks_d;
			expected_crc_q <= expected_crc_d;
			running_crc_q  <= running_crc_d;
			byte_index_q   <= byte_index_d;
		end
	end

	// last payload byte is taken straight from the input, so it is never stored
	always_ff @(posedge clk) begin
		if (store_we && (byte_index_q < STORE_DEPTH_IDX)) begin
			payload_q[byte_index_q] <= rx_byte;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		idle_ticks_d   = idle_ticks_q;
		expected_crc_d = expected_crc_q;
		running_crc_d  = running_crc_q;
		byte_index_d   = byte_index_q;
		store_we       = 1'b0;
		res            = '0;
		if (en) begin
			if (mode == MODE_TICK) begin
				if (phase_q != PH_IDLE) begin
					if (idle_ticks_q >= cfg.timeout_ticks) begin
						phase_d      = PH_IDLE;
						idle_ticks_d = '0;
						res.valid    = 1'b1;
						res.status   = ST_TIMEOUT;
					end else begin
						idle_ticks_d = idle_ticks_q + TICK_W'(1);
					end
				end
			end else begin
				idle_ticks_d = '0;
				case (phase_q)
					PH_IDLE: begin
						res.valid = 1'b1;
						if (rx_byte == cfg.start_byte) begin
							phase_d     = PH_LEN;
							res.status  = ST_ECHO;
							res.tx_byte = cfg.start_byte;
						end else begin
							res.status  = ST_BAD_START;
						end
					end
					PH_LEN: begin
						if (rx_byte == FRAME_LEN_BYTE) begin
							phase_d = PH_CRC;
						end else begin
							phase_d    = PH_IDLE;
							res.valid  = 1'b1;
							res.status = ST_BAD_LEN;
						end
					end
					PH_CRC: begin
						expected_crc_d = rx_byte;
						running_crc_d  = '0;
						byte_index_d   = '0;
						phase_d        = PH_DATA;
					end
					PH_DATA: begin
						store_we      = 1'b1;
						running_crc_d = crc_nxt;
						if (byte_index_q == LAST_IDX) begin
							phase_d          = PH_IDLE;
							byte_index_d     = '0;
							res.valid        = 1'b1;
							res.received_crc = expected_crc_q;
							res.computed_crc = crc_nxt;
							if (crc_nxt != expected_crc_q) begin
								res.status = ST_CRC_ERR;
							end else begin
								res.status  = ST_GOOD;
								res.year    = {payload_q[1], payload_q[0]};
								res.month   = payload_q[2];
								res.day     = payload_q[3];
								res.weekday = payload_q[4];
								res.hour    = payload_q[5];
								res.minute  = payload_q[6];
								res.second  = payload_q[7];
								res.millis  = {rx_byte, payload_q[8]};
							end
						end else begin
							byte_index_d = byte_index_q + IDX_W'(1);
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

endmodule

// ===== sv/crc8_checked_frame_receiver_unit.sv =====
// an input transfer is registered in stage 1, and its result in the output register
// one byte or tick per cycle unless a result stalls, with combinational crc and decode
// no result from ticks that do not time out, a valid length, the crc or inner payload bytes
// reset: frame logic back to idle, counters and crc cleared, both stream stages empty
// reset: start byte returns to 0xfe and the timeout to 100000 ticks
// ----------------------------------------------------------------------------
// crc8_checked_frame_receiver_unit
// stream wrapper: input register, frame core, output register with apb config
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver_unit
	import crc8fr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
	input  logic                  s_axis_tuser,  // [0] mode
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] tx_byte, [15:8] received_crc, [23:16] computed_crc, [39:24] year,
	// [47:40] month, [55:48] day, [63:56] weekday, [71:64] hour,
	// [79:72] minute, [87:80] second, [103:88] millis
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [2:0]            m_axis_tuser,  // [2:0] status
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       vld_s1;
	logic       mode_s1;
	logic [7:0] rx_byte_s1;
	logic       m_vld_q;
	logic       advance;
	logic       in_xfer;

	// stage 1 moves on whenever the output register is free or being drained
	assign advance       = vld_s1 & (~m_vld_q | m_axis_tready);
	assign s_axis_tready = ~vld_s1 | advance;
	assign in_xfer       = s_axis_tvalid & s_axis_tready;

	crc8fr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crc8fr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.mode    (mode_s1),
		.rx_byte (rx_byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			m_vld_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				m_vld_q <= res.valid;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1    <= s_axis_tuser;
			rx_byte_s1 <= s_axis_tdata;
		end
		if (advance && res.valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tdata  = {res_q.millis, res_q.second, res_q.minute, res_q.hour,
		res_q.weekday, res_q.day, res_q.month, res_q.year,
		res_q.computed_crc, res_q.received_crc, res_q.tx_byte};

endmodule

// ===== sv/crc8fr_checker.sv =====
// ----------------------------------------------------------------------------
// crc8fr_checker
// port-level checks on the result stream, bound to the receiver top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8fr_checker
	import crc8fr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [2:0]            m_axis_tuser
);

	logic is_good;
	logic is_crc_err;
	logic is_not_echo;
	logic crc_match;

	assign is_good     = m_axis_tvalid && (m_axis_tuser == ST_GOOD);
	assign is_crc_err  = m_axis_tvalid && (m_axis_tuser == ST_CRC_ERR);
	assign is_not_echo = m_axis_tvalid && (m_axis_tuser != ST_ECHO);
	assign crc_match   = m_axis_tdata[15:8] == m_axis_tdata[23:16];

	// a stalled result stays offered
	`CHK_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// only the echo carries a byte to transmit
	`CHK_SAME(a_tx_echo_only, clk, arst_n, is_not_echo, m_axis_tdata[7:0] == 8'h00)
	// a good frame means the header crc matched the payload crc
	`CHK_SAME(a_good_crc, clk, arst_n, is_good, crc_match)
	// a crc error means they differ, and no time fields leak out
	`CHK_SAME(a_err_crc, clk, arst_n, is_crc_err, !crc_match && (m_axis_tdata[103:24] == '0))

endmodule

bind crc8_checked_frame_receiver_unit crc8fr_checker u_crc8fr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/crc8_checked_frame_receiver_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc8_checked_frame_receiver_unit_tb
// Self-checking bench for the crc-8 framed time receiver. A short table of
// directed bytes and ticks comes first. Random traffic follows: mostly
// well-formed frames with random payloads, plus noise, broken headers and
// tick runs that time out, under four register settings: three with random
// gaps and stalls on both streams, one with a long hold-off. Every result is
// checked field by field against the table or a cycle-free frame model.
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver_unit_tb;

	import crc8fr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 190;
	localparam int HOLD_CYCLES = 300;

	// packed so that {tuser, tdata} maps straight onto it
	typedef struct packed {
		status_t     status;
		logic [15:0] millis;
		logic [7:0]  second;
		logic [7:0]  minute;
		logic [7:0]  hour;
		logic [7:0]  weekday;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [15:0] year;
		logic [7:0]  computed_crc;
		logic [7:0]  received_crc;
		logic [7:0]  tx_byte;
	} frame_result_t;

	typedef struct {
		logic       mode;
		logic [7:0] data;
		bit         typed;
		bit         has_res;
		status_t    status;
		logic [7:0] tx;
	} stim_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  s_axis_tuser  = MODE_BYTE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [2:0]            m_axis_tuser;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr         = '0;
	logic [CFG_DATA_W-1:0] pwdata        = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// register copies and frame state of the model
	logic [7:0]        cfg_start   = START_RST;
	logic [TICK_W-1:0] cfg_timeout = TIMEOUT_RST;
	phase_t            frame_phase = PH_IDLE;
	logic [TICK_W-1:0] tick_count  = '0;
	logic [7:0]        hdr_crc     = '0;
	logic [7:0]        run_crc     = '0;
	logic [IDX_W-1:0]  pay_idx     = '0;
	logic [7:0]        frame_bytes [FRAME_LEN];

	frame_result_t pending_outcomes [$];
	int            error_count  = 0;
	int            cycle_count  = 0;
	int            phase_items  = 0;
	int            tx_gap_pct   = 28;
	int            rx_stall_pct = 55;
	bit            hold_go      = 1'b0;
	int            hold_left    = 0;

	stim_row_t directed_rows [22] = '{
		'{MODE_TICK, 8'h5a, 1, 0, ST_ECHO,      8'h00},  // tick while idle is dropped
		'{MODE_BYTE, 8'h00, 1, 1, ST_BAD_START, 8'h00},
		'{MODE_BYTE, 8'hff, 1, 1, ST_BAD_START, 8'h00},
		'{MODE_BYTE, 8'hfe, 1, 1, ST_ECHO,      8'hfe},
		'{MODE_BYTE, 8'h0b, 1, 1, ST_BAD_LEN,   8'h00},
		'{MODE_BYTE, 8'hfe, 1, 1, ST_ECHO,      8'hfe},
		'{MODE_BYTE, 8'hff, 1, 1, ST_BAD_LEN,   8'h00},
		'{MODE_BYTE, 8'hfe, 1, 1, ST_ECHO,      8'hfe},
		'{MODE_TICK, 8'ha5, 0, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h0a, 1, 0, ST_ECHO,      8'h00},
		'{MODE_TICK, 8'hff, 0, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		// all-zero payload: crc of zeros is zero, every time field zero
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 0, ST_ECHO,      8'h00},
		'{MODE_BYTE, 8'h00, 1, 1, ST_GOOD,      8'h00}
	};

	crc8_checked_frame_receiver_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
		.s_axis_tuser  (s_axis_tuser),   // [0] mode
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [7:0] tx_byte .. [103:88] millis
		.m_axis_tuser  (m_axis_tuser),   // [2:0] status
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #4 clk = ~clk;

	// msb-first crc-8, fed one input bit at a time
	function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	// advances the frame state by one byte or tick, returns 1 when a result is due
	function automatic bit receiver_outcome(input logic mode, input logic [7:0] b,
			output frame_result_t r);
		r = '0;
		if (mode == MODE_TICK) begin
			if (frame_phase == PH_IDLE) begin
				return 1'b0;
			end
			if (tick_count >= cfg_timeout) begin
				frame_phase = PH_IDLE;
				tick_count  = '0;
				r.status    = ST_TIMEOUT;
				return 1'b1;
			end
			tick_count = tick_count + 1'b1;
			return 1'b0;
		end
		tick_count = '0;
		case (frame_phase)
			PH_IDLE: begin
				if (b == cfg_start) begin
					frame_phase = PH_LEN;
					r.status    = ST_ECHO;
					r.tx_byte   = cfg_start;
				end else begin
					r.status = ST_BAD_START;
				end
				return 1'b1;
			end
			PH_LEN: begin
				if (b == FRAME_LEN_BYTE) begin
					frame_phase = PH_CRC;
					return 1'b0;
				end
				frame_phase = PH_IDLE;
				r.status    = ST_BAD_LEN;
				return 1'b1;
			end
			PH_CRC: begin
				hdr_crc     = b;
				run_crc     = '0;
				pay_idx     = '0;
				frame_phase = PH_DATA;
				return 1'b0;
			end
			default: begin
			end
		endcase
		frame_bytes[pay_idx] = b;
		run_crc = crc8_next(run_crc, b);
		pay_idx = pay_idx + 1'b1;
		if (pay_idx < FRAME_LEN) begin
			return 1'b0;
		end
		frame_phase    = PH_IDLE;
		pay_idx        = '0;
		r.received_crc = hdr_crc;
		r.computed_crc = run_crc;
		if (run_crc != hdr_crc) begin
			r.status = ST_CRC_ERR;
			return 1'b1;
		end
		r.status  = ST_GOOD;
		r.year    = {frame_bytes[1], frame_bytes[0]};
		r.month   = frame_bytes[2];
		r.day     = frame_bytes[3];
		r.weekday = frame_bytes[4];
		r.hour    = frame_bytes[5];
		r.minute  = frame_bytes[6];
		r.second  = frame_bytes[7];
		r.millis  = {frame_bytes[9], frame_bytes[8]};
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	// one input transfer; a typed row overrides what the model predicts
	task automatic offer(input logic mode, input logic [7:0] b, input bit typed = 1'b0,
			input bit typed_has = 1'b0, input frame_result_t typed_res = '0);
		frame_result_t r;
		bit            has;
		while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = mode;
		s_axis_tdata  = b;
		do @(posedge clk); while (!s_axis_tready);
		if (!(mode == MODE_TICK && frame_phase == PH_IDLE)) begin
			phase_items++;
		end
		has = receiver_outcome(mode, b, r);
		if (typed) begin
			has = typed_has;
			r   = typed_res;
		end
		if (has) begin
			pending_outcomes.push_back(r);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// write a register with junk above its width, then read it back
	task automatic cfg_write(input logic reg_sel, input logic [TICK_W-1:0] value);
		logic [CFG_DATA_W-1:0] junk;
		logic [CFG_DATA_W-1:0] want;
		junk = $urandom;
		if (reg_sel == REG_START) begin
			want   = {24'h0, value[7:0]};
			pwdata = {junk[31:8], value[7:0]};
		end else begin
			want   = {12'h0, value};
			pwdata = {junk[31:20], value};
		end
		paddr   = CFG_ADDR_W'({reg_sel, 2'b00});
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		pwrite  = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		check_field(reg_sel == REG_START ? "start_byte" : "timeout_ticks",
			want[15:0], prdata[15:0]);
		check_field("register upper bits", want[31:16], prdata[31:16]);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (reg_sel == REG_START) begin
			cfg_start = value[7:0];
		end else begin
			cfg_timeout = value;
		end
	endtask

	// all results in, plus room for items that produce none
	task automatic settle();
		while (pending_outcomes.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic tick_gap();
		int cap;
		cap = (cfg_timeout < 8) ? int'(cfg_timeout) + 1 : 3;
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, cap)) offer(MODE_TICK, 8'($urandom));
		end
	endtask

	task automatic random_traffic();
		logic [7:0] body [FRAME_LEN];
		logic [7:0] sum;
		int         style;
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 3)) begin
				offer($urandom_range(1) ? MODE_TICK : MODE_BYTE, 8'($urandom));
			end
			return;
		end
		style = $urandom_range(9);
		sum   = 8'h00;
		for (int i = 0; i < FRAME_LEN; i++) begin
			body[i] = (style == 0) ? 8'h00 : (style == 1) ? 8'hff : 8'($urandom);
			sum     = crc8_next(sum, body[i]);
		end
		tick_gap();
		offer(MODE_BYTE, ($urandom_range(99) < 92) ? cfg_start : 8'($urandom));
		tick_gap();
		offer(MODE_BYTE, ($urandom_range(99) < 92) ? FRAME_LEN_BYTE : 8'($urandom));
		tick_gap();
		offer(MODE_BYTE, ($urandom_range(99) < 60) ? sum : 8'($urandom));
		for (int i = 0; i < FRAME_LEN; i++) begin
			tick_gap();
			offer(MODE_BYTE, body[i]);
		end
	endtask

	// result side: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go   = 1'b0;
		end
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else begin
			m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = frame_result_t'({m_axis_tuser, m_axis_tdata});
			if (pending_outcomes.size() == 0) begin
				$error("result transfer with nothing pending, status %0d", m_axis_tuser);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("status", 16'(want.status), 16'(got.status));
				check_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
				check_field("received_crc", 16'(want.received_crc), 16'(got.received_crc));
				check_field("computed_crc", 16'(want.computed_crc), 16'(got.computed_crc));
				check_field("year", want.year, got.year);
				check_field("month", 16'(want.month), 16'(got.month));
				check_field("day", 16'(want.day), 16'(got.day));
				check_field("weekday", 16'(want.weekday), 16'(got.weekday));
				check_field("hour", 16'(want.hour), 16'(got.hour));
				check_field("minute", 16'(want.minute), 16'(got.minute));
				check_field("second", 16'(want.second), 16'(got.second));
				check_field("millis", want.millis, got.millis);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [7:0]        start_set [4];
		logic [TICK_W-1:0] limit_set [4];
		int                gap_set   [4];
		int                stall_set [4];
		frame_result_t     row_res;
		bit                paused;
		start_set    = '{8'h00, 8'hff, 8'h00, 8'ha5};
		start_set[2] = 8'($urandom);
		limit_set    = '{20'd1, 20'hfffff, 20'd3, 20'd2};
		limit_set[3] = TICK_W'($urandom_range(2, 6));
		gap_set      = '{28, 55, 55, 0};
		stall_set    = '{55, 28, 28, 0};
		paused       = 1'b0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows run on the reset register values
		foreach (directed_rows[i]) begin
			row_res        = '0;
			row_res.status = directed_rows[i].status;
			row_res.tx_byte = directed_rows[i].tx;
			offer(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].typed,
				directed_rows[i].has_res, row_res);
		end

		for (int p = 0; p < 4; p++) begin
			settle();
			if (p[0]) begin
				cfg_write(REG_TIMEOUT, limit_set[p]);
				cfg_write(REG_START, TICK_W'(start_set[p]));
			end else begin
				cfg_write(REG_START, TICK_W'(start_set[p]));
				cfg_write(REG_TIMEOUT, limit_set[p]);
			end
			tx_gap_pct   = gap_set[p];
			rx_stall_pct = stall_set[p];
			phase_items  = 0;
			if (p == 3) begin
				hold_go = 1'b1;
			end
			while (phase_items < PHASE_ITEMS) begin
				if (p == 1 && !paused && phase_items >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					while (pending_outcomes.size() != 0) begin
						@(negedge clk);
					end
				end
				random_traffic();
			end
			// leave the frame logic idle before the next register write
			while (frame_phase != PH_IDLE) begin
				offer(MODE_BYTE, (frame_phase == PH_LEN) ? 8'h00 : 8'($urandom));
			end
		end

		while (pending_outcomes.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/crc8fr_pkg.sv
sv/crc8fr_regs.sv
sv/crc8fr_core.sv
sv/crc8_checked_frame_receiver_unit.sv
sv/crc8fr_checker.sv
tb/sv/crc8_checked_frame_receiver_unit_tb.sv
